>>> rtl/qwu_pkg.sv
// Shared types, constants and a helper function for the Quickprop weight update block.
package qwu_pkg;

    localparam int Q_FRAC       = 16;
    localparam int STEP_THR     = 65;
    localparam int W_LIMIT      = 98304000;
    localparam int TERM_LOG     = 48;
    localparam int QUOT_BITS    = TERM_LOG + 1;
    localparam int FIFO_DEPTH   = 4;
    localparam int SDIV_BITS    = 47;

    localparam logic [30:0] LR_RST     = 31'd45875;
    localparam logic [15:0] BS_RST     = 16'd1;
    localparam logic [31:0] DECAY_RST  = 32'hFFFF_FFFA;
    localparam logic [30:0] MU_RST     = 31'd114688;
    // Step size and shrink factor that follow from the reset register values
    localparam logic [30:0] EPS_RST    = 31'd45875;
    localparam logic [16:0] SHRINK_RST = 17'd41704;

    typedef enum logic [1:0] {
        REG_LRATE  = 2'd0,
        REG_NBATCH = 2'd1,
        REG_DECAY  = 2'd2,
        REG_MU     = 2'd3
    } reg_index_t;

    typedef enum logic [1:0] {
        CFG_IDLE = 2'd0,
        CFG_EPS  = 2'd1,
        CFG_SHR  = 2'd2
    } cfg_state_t;

    // Configuration values seen by the datapath
    typedef struct packed {
        logic signed [31:0] decay;
        logic        [30:0] mu;
        logic        [30:0] eps;
        logic        [16:0] shrink;
        logic               busy;
    } cfg_bus_t;

    // Classified item between front and back
    typedef struct packed {
        logic signed [31:0] w;
        logic signed [31:0] slope;
        logic               flag;
        logic               grad_on;
        logic               mom;
        logic               sec;
        logic signed [63:0] p_es;
        logic signed [63:0] p_mu;
        logic signed [63:0] num;
        logic signed [32:0] den;
    } q_item_t;

    // Divider pipeline stage contents
    typedef struct packed {
        logic signed [31:0] w;
        logic signed [31:0] slope;
        logic               flag;
        logic               sec;
        logic               dz;
        logic               big;
        logic               zero_num;
        logic               qneg;
        logic signed [63:0] partial;
        logic        [63:0] rem;
        logic        [32:0] d;
        logic [QUOT_BITS-1:0] quot;
    } div_t;

    // Divide a Q32.32 product by 2^16, truncating toward zero
    function automatic logic signed [63:0] trunc16(input logic signed [63:0] p);
        logic signed [63:0] bias;
        bias = p[63] ? 64'sd65535 : 64'sd0;
        return (p + bias) >>> Q_FRAC;
    endfunction

endpackage

>>> rtl/qwu_cfg.sv
// Configuration registers and the serial divider for step size and shrink factor.
module qwu_cfg (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [1:0]           cfg_index,
    input  logic [31:0]          cfg_data,
    output qwu_pkg::cfg_bus_t    cfg_out
);
    import qwu_pkg::*;

    logic [30:0] lr_reg;
    logic [15:0] bs_reg;
    logic signed [31:0] decay_reg;
    logic [30:0] mu_reg;
    logic [30:0] eps_reg;
    logic [16:0] shrink_reg;
    cfg_state_t  state_reg, state_next;
    logic [5:0]  cnt_reg;
    logic [SDIV_BITS-1:0] dvd_reg;
    logic [31:0] rem_reg;
    logic [31:0] dvs_reg;
    logic        wr, start, last_bit;
    logic [32:0] rem_sh;
    logic        qbit;
    logic [32:0] rem_sub;

    assign wr        = cfg_valid && cfg_ready;
    assign start     = wr && (reg_index_t'(cfg_index) != REG_DECAY);
    assign last_bit  = (cnt_reg == 6'(SDIV_BITS - 1));
    assign cfg_ready = (state_reg == CFG_IDLE);

    // One quotient bit per cycle
    assign rem_sh  = {rem_reg, dvd_reg[SDIV_BITS-1]};
    assign qbit    = (rem_sh >= {1'b0, dvs_reg});
    assign rem_sub = rem_sh - {1'b0, dvs_reg};

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            CFG_IDLE: if (start) state_next = CFG_EPS;
            CFG_EPS:  if (last_bit) state_next = CFG_SHR;
            CFG_SHR:  if (last_bit) state_next = CFG_IDLE;
            default:  state_next = CFG_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        cfg_out.decay  = decay_reg;
        cfg_out.mu     = mu_reg;
        cfg_out.eps    = eps_reg;
        cfg_out.shrink = shrink_reg;
        cfg_out.busy   = (state_reg != CFG_IDLE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= CFG_IDLE;
            lr_reg     <= LR_RST;
            bs_reg     <= BS_RST;
            decay_reg  <= DECAY_RST;
            mu_reg     <= MU_RST;
            eps_reg    <= EPS_RST;
            shrink_reg <= SHRINK_RST;
            cnt_reg    <= '0;
        end else begin
            state_reg <= state_next;
            // Take register writes
            if (wr) begin
                unique case (reg_index_t'(cfg_index))
                    REG_LRATE:  lr_reg    <= cfg_data[30:0];
                    REG_NBATCH: bs_reg    <= cfg_data[15:0];
                    REG_DECAY:  decay_reg <= cfg_data;
                    REG_MU:     mu_reg    <= cfg_data[30:0];
                    default: ;
                endcase
            end
            if (state_reg == CFG_IDLE) begin
                cnt_reg <= '0;
            end else begin
                cnt_reg <= last_bit ? 6'd0 : cnt_reg + 6'd1;
                if (last_bit && state_reg == CFG_EPS) eps_reg <= {dvd_reg[29:0], qbit};
                if (last_bit && state_reg == CFG_SHR) shrink_reg <= {dvd_reg[15:0], qbit};
            end
        end
    end

    // Divider datapath: load operands, then shift quotient bits in
    always_ff @(posedge aclk) begin
        if (state_reg == CFG_IDLE || (state_reg == CFG_EPS && last_bit)) begin
            rem_reg <= '0;
            if (state_reg == CFG_IDLE) begin
                dvd_reg <= {16'd0, (reg_index_t'(cfg_index) == REG_LRATE)
                                   ? cfg_data[30:0] : lr_reg};
                if (reg_index_t'(cfg_index) == REG_NBATCH)
                    dvs_reg <= (cfg_data[15:0] == 16'd0) ? 32'd1 : {16'd0, cfg_data[15:0]};
                else
                    dvs_reg <= (bs_reg == 16'd0) ? 32'd1 : {16'd0, bs_reg};
            end else begin
                dvd_reg <= {mu_reg, 16'd0};
                dvs_reg <= 32'd65536 + {1'b0, mu_reg};
            end
        end else begin
            rem_reg <= qbit ? rem_sub[31:0] : rem_sh[31:0];
            dvd_reg <= {dvd_reg[SDIV_BITS-2:0], qbit};
        end
    end

endmodule

>>> rtl/qwu_front.sv
// Front part: slope with decay, products and branch classification over three stages.
module qwu_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  qwu_pkg::cfg_bus_t    cfg,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [127:0]         in_data,
    input  logic                 q_full,
    output logic                 push,
    output qwu_pkg::q_item_t     push_item
);
    import qwu_pkg::*;

    logic fe;
    logic f1_valid_reg, f2_valid_reg, f3_valid_reg;
    logic signed [31:0] f1_w_reg, f1_g_reg, f1_sp_reg, f1_st_reg;
    logic signed [63:0] f1_pdw_reg, f1_rhs_reg, f1_pmu_reg;
    logic signed [31:0] f2_w_reg, f2_sp_reg, f2_st_reg, f2_slope_reg;
    logic signed [63:0] f2_rhs_reg, f2_pmu_reg;
    logic               f2_flag_reg;
    q_item_t            f3_reg, f3_next;
    logic signed [63:0] slope_wide;
    logic signed [63:0] lhs;
    logic               band, pos;

    // Advance all stages together unless the last one cannot push
    assign fe        = !f3_valid_reg || !q_full;
    assign in_ready  = fe && !cfg.busy;
    assign push      = f3_valid_reg && fe;
    assign push_item = f3_reg;

    assign slope_wide = 64'(f1_g_reg) + trunc16(f1_pdw_reg);

    // Classify on the previous step and the secant comparison
    always_comb begin
        band = (f2_st_reg > 32'sd65) || (f2_st_reg < -32'sd65);
        pos  = (f2_st_reg > 32'sd65);
        lhs  = 64'(f2_slope_reg) <<< Q_FRAC;
        f3_next.w     = f2_w_reg;
        f3_next.slope = f2_slope_reg;
        f3_next.flag  = f2_flag_reg;
        f3_next.grad_on = band ? (pos ? (f2_slope_reg > 0) : (f2_slope_reg < 0)) : 1'b1;
        f3_next.mom   = band && (pos ? (lhs > f2_rhs_reg) : (lhs < f2_rhs_reg));
        f3_next.sec   = band && !f3_next.mom;
        f3_next.p_es  = $signed({1'b0, cfg.eps}) * f2_slope_reg;
        f3_next.p_mu  = f2_pmu_reg;
        f3_next.num   = f2_st_reg * f2_slope_reg;
        f3_next.den   = 33'(f2_sp_reg) - 33'(f2_slope_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
            f3_valid_reg <= 1'b0;
        end else if (fe) begin
            f1_valid_reg <= in_valid && in_ready;
            f2_valid_reg <= f1_valid_reg;
            f3_valid_reg <= f2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (fe) begin
            // Stage 1: register fields, form products on the inputs
            f1_w_reg   <= in_data[31:0];
            f1_g_reg   <= in_data[63:32];
            f1_sp_reg  <= in_data[95:64];
            f1_st_reg  <= in_data[127:96];
            f1_pdw_reg <= cfg.decay * $signed(in_data[31:0]);
            f1_rhs_reg <= 64'($signed({1'b0, cfg.shrink}) * $signed(in_data[95:64]));
            f1_pmu_reg <= $signed({1'b0, cfg.mu}) * $signed(in_data[127:96]);
            // Stage 2: saturated slope
            f2_w_reg   <= f1_w_reg;
            f2_sp_reg  <= f1_sp_reg;
            f2_st_reg  <= f1_st_reg;
            f2_rhs_reg <= f1_rhs_reg;
            f2_pmu_reg <= f1_pmu_reg;
            if (slope_wide > 64'sd2147483647) begin
                f2_slope_reg <= 32'sh7FFF_FFFF;
                f2_flag_reg  <= 1'b1;
            end else if (slope_wide < -64'sd2147483648) begin
                f2_slope_reg <= 32'sh8000_0000;
                f2_flag_reg  <= 1'b1;
            end else begin
                f2_slope_reg <= slope_wide[31:0];
                f2_flag_reg  <= 1'b0;
            end
            // Stage 3: classified item
            f3_reg <= f3_next;
        end
    end

endmodule

>>> rtl/qwu_fifo.sv
// Short queue between the front and back parts.
module qwu_fifo #(
    parameter int DEPTH = qwu_pkg::FIFO_DEPTH
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  qwu_pkg::q_item_t   push_item,
    input  logic               pop,
    output qwu_pkg::q_item_t   head,
    output logic               empty,
    output logic               full
);
    import qwu_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    q_item_t        mem_reg [DEPTH];
    logic [AW-1:0]  wp_reg, rp_reg;
    logic [CW-1:0]  cnt_reg;

    assign empty = (cnt_reg == '0);
    assign full  = (cnt_reg == CW'(DEPTH));
    assign head  = mem_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wp_reg] <= push_item;
    end

    // Advance pointers and count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) wp_reg <= (wp_reg == AW'(DEPTH - 1)) ? '0 : wp_reg + 1'b1;
            if (pop)  rp_reg <= (rp_reg == AW'(DEPTH - 1)) ? '0 : rp_reg + 1'b1;
            if (push && !pop)      cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push) cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

>>> rtl/qwu_back.sv
// Back part: step terms, pipelined secant divider, weight clip and output register.
module qwu_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  qwu_pkg::q_item_t   head,
    input  logic               empty,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [95:0]        out_data
);
    import qwu_pkg::*;

    localparam int NS = QUOT_BITS;
    localparam int XW = 33 + QUOT_BITS;

    logic  be;
    logic  v_reg [NS+1];
    div_t  st_reg [NS+1];
    div_t  b0_next;
    logic  out_valid_reg;
    logic [95:0] out_reg;
    logic [63:0] nmag;
    logic [32:0] dmag;

    logic [QUOT_BITS-1:0] qmag;
    logic signed [63:0]   q, step, nw;
    logic signed [31:0]   st_out;
    logic                 st_sat;
    logic signed [27:0]   nw_out;

    // Stall the whole back pipeline only while the result is held
    assign be        = !out_valid_reg || out_ready;
    assign pop       = be && !empty;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Terms and divider operands
    always_comb begin
        nmag = head.num[63] ? 64'(-head.num) : head.num;
        dmag = head.den[32] ? 33'(-head.den) : head.den;
        b0_next.w        = head.w;
        b0_next.slope    = head.slope;
        b0_next.flag     = head.flag;
        b0_next.sec      = head.sec;
        b0_next.dz       = head.sec && (head.den == '0);
        b0_next.big      = ({dmag, QUOT_BITS'(0)} <= {(XW-64)'(0), nmag});
        b0_next.zero_num = (head.num == '0);
        b0_next.qneg     = head.num[63] ^ head.den[32];
        b0_next.partial  = (head.grad_on ? trunc16(head.p_es) : 64'sd0)
                         + (head.mom ? trunc16(head.p_mu) : 64'sd0);
        b0_next.rem      = nmag;
        b0_next.d        = dmag;
        b0_next.quot     = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) v_reg[0] <= 1'b0;
        else if (be)  v_reg[0] <= !empty;
    end

    always_ff @(posedge aclk) begin
        if (be) st_reg[0] <= b0_next;
    end

    // One quotient bit per stage, most significant first
    for (genvar i = 0; i < NS; i++) begin : g_div
        localparam int K = NS - 1 - i;
        logic [XW-1:0] dsh, remx, diff;
        div_t          nxt;

        always_comb begin
            dsh  = {(XW-33)'(0), st_reg[i].d} << K;
            remx = {(XW-64)'(0), st_reg[i].rem};
            diff = remx - dsh;
            nxt  = st_reg[i];
            if (dsh <= remx) begin
                nxt.rem     = diff[63:0];
                nxt.quot[K] = 1'b1;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) v_reg[i+1] <= 1'b0;
            else if (be)  v_reg[i+1] <= v_reg[i];
        end

        always_ff @(posedge aclk) begin
            if (be) st_reg[i+1] <= nxt;
        end
    end

    // Limit the quotient, sum the step, clip the weight
    always_comb begin
        if (st_reg[NS].big)
            qmag = st_reg[NS].zero_num ? '0 : QUOT_BITS'(1) << TERM_LOG;
        else if (st_reg[NS].quot > (QUOT_BITS'(1) << TERM_LOG))
            qmag = QUOT_BITS'(1) << TERM_LOG;
        else
            qmag = st_reg[NS].quot;
        q = st_reg[NS].sec ? (st_reg[NS].qneg ? -64'(qmag) : 64'(qmag)) : 64'sd0;
        step = st_reg[NS].partial + q;
        nw   = 64'(st_reg[NS].w) + step;
        if (nw > 64'(W_LIMIT))       nw_out = 28'(W_LIMIT);
        else if (nw < -64'(W_LIMIT)) nw_out = 28'(-W_LIMIT);
        else                         nw_out = nw[27:0];
        st_sat = 1'b1;
        if (step > 64'sd2147483647)       st_out = 32'sh7FFF_FFFF;
        else if (step < -64'sd2147483648) st_out = 32'sh8000_0000;
        else begin
            st_out = step[31:0];
            st_sat = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn)  out_valid_reg <= 1'b0;
        else if (be)   out_valid_reg <= v_reg[NS];
    end

    always_ff @(posedge aclk) begin
        if (be) out_reg <= {3'd0, st_reg[NS].flag | st_reg[NS].dz | st_sat,
                            st_reg[NS].slope, st_out, nw_out};
    end

endmodule

>>> rtl/quickprop_weight_update.sv
// Pipeline: 3 front stages, the queue, 51 back stages (terms, 49 divider bits, output).
// Throughput: one transaction per cycle while the result is not held; the secant divider is fully
// pipelined, one bit per stage. A write to the rate, batch count or mu register recomputes step
// size and shrink factor on a shared serial divider, during which no input transaction is taken.
// Reset (aresetn low, synchronous) empties the pipeline and queue and loads register defaults.
module quickprop_weight_update #(
    parameter int FIFO_DEPTH = qwu_pkg::FIFO_DEPTH
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [127:0]  s_tdata,   // weight, gradient, last_slope, last_step
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [95:0]   m_tdata,   // new_weight, new_step, new_slope, saturated, zero pad
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [1:0]    cfg_index,
    input  logic [31:0]   cfg_data
);
    import qwu_pkg::*;

    cfg_bus_t cfg;
    q_item_t  push_item, head;
    logic     push, pop, empty, full;

    qwu_cfg u_cfg (
        .aclk, .aresetn, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .cfg_out(cfg)
    );

    qwu_front u_front (
        .aclk, .aresetn, .cfg,
        .in_valid(s_tvalid), .in_ready(s_tready), .in_data(s_tdata),
        .q_full(full), .push, .push_item
    );

    qwu_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
        .aclk, .aresetn, .push, .push_item, .pop, .head, .empty, .full
    );

    qwu_back u_back (
        .aclk, .aresetn, .head, .empty, .pop,
        .out_valid(m_tvalid), .out_ready(m_tready), .out_data(m_tdata)
    );

endmodule

>>> rtl/qwu_checker.sv
// Port-level checker for the Quickprop weight update block, bound to the top level.
module qwu_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [95:0]  m_tdata,
    input logic         cfg_valid,
    input logic         cfg_ready,
    input logic [1:0]   cfg_index
);
    import qwu_pkg::*;

    // Reset empties the result side
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // Held result stays put
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Weight stays inside the clip range
    a_clip: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(m_tdata[27:0]) <= 28'sd98304000) &&
                     ($signed(m_tdata[27:0]) >= -28'sd98304000))
        else $error("new_weight outside clip range");

    // Recompute after a rate, batch count or mu write blocks input
    a_recompute: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid && cfg_ready &&
        (cfg_index == REG_LRATE || cfg_index == REG_NBATCH ||
         cfg_index == REG_MU) |=> !s_tready && !cfg_ready)
        else $error("input taken during recompute");

endmodule

bind quickprop_weight_update qwu_checker u_qwu_checker (
    .aclk, .aresetn, .s_tready, .m_tvalid, .m_tready, .m_tdata,
    .cfg_valid, .cfg_ready, .cfg_index
);

>>> tb/tb_quickprop_weight_update.sv
// Self-checking testbench for the Quickprop weight update stream block.
`timescale 1ns / 100ps

module tb_quickprop_weight_update;
    import qwu_pkg::*;

    localparam longint ONE_Q     = 65536;
    localparam longint W_CLIP    = 98304000;
    localparam longint QUOT_CLIP = 64'sd281474976710656;
    localparam int     DRAIN_CYC = 70;
    localparam int     HOLD_CYC  = 400;
    localparam int     CYC_LIMIT = 600000;
    localparam int     N_DIR     = 14;

    typedef struct packed {
        logic               sat;
        logic signed [31:0] slope;
        logic signed [31:0] step;
        logic signed [27:0] nw;
    } upd_res_t;

    typedef struct packed {
        logic signed [31:0] stp;
        logic signed [31:0] sp;
        logic signed [31:0] g;
        logic signed [31:0] w;
    } upd_in_t;

    typedef struct {
        upd_in_t  din;
        bit       known;
        upd_res_t res;
    } dir_row_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] s_tdata;    // weight, gradient, last_slope, last_step
    logic         m_tvalid;
    logic         m_tready;
    logic [95:0]  m_tdata;    // new_weight, new_step, new_slope, saturated, zero pad
    logic         cfg_valid;
    logic         cfg_ready;
    logic [1:0]   cfg_index;
    logic [31:0]  cfg_data;

    // Predictor copy of the register file
    logic [30:0]        lr_q;
    logic [15:0]        bs_q;
    logic signed [31:0] decay_q;
    logic [30:0]        mu_q;

    upd_res_t updates_due[$];
    dir_row_t dir_tab[N_DIR];
    int  errors;
    int  cycles;
    bit  quiet;
    bit  long_hold;

    quickprop_weight_update uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always begin
        aclk = 1'b1; #1;
        aclk = 1'b0; #1;
    end

    // Slope with decay, before saturation
    function automatic longint raw_slope(input logic signed [31:0] w, input logic signed [31:0] g);
        longint dw;
        dw = longint'(decay_q) * longint'(w);
        return longint'(g) + dw / ONE_Q;
    endfunction

    // Compute the expected weight update under the current registers
    function automatic upd_res_t predict_update(input upd_in_t x);
        longint bs, eps, mu, shrink, slope, step, lhs, rhs, num, den, q, nw, spv, stv;
        bit flag, pos;
        upd_res_t r;
        flag = 0;
        step = 0;
        spv = longint'(x.sp);
        stv = longint'(x.stp);
        bs = (bs_q == 0) ? 1 : longint'(bs_q);
        eps = longint'(lr_q) / bs;
        mu = longint'(mu_q);
        shrink = (mu * ONE_Q) / (ONE_Q + mu);
        slope = raw_slope(x.w, x.g);
        if (slope > 64'sd2147483647) begin
            slope = 64'sd2147483647; flag = 1;
        end else if (slope < -64'sd2147483648) begin
            slope = -64'sd2147483648; flag = 1;
        end
        if (stv > STEP_THR || stv < -STEP_THR) begin
            pos = stv > STEP_THR;
            lhs = slope * ONE_Q;
            rhs = shrink * spv;
            if (pos ? (slope > 0) : (slope < 0))
                step += (eps * slope) / ONE_Q;
            if (pos ? (lhs > rhs) : (lhs < rhs)) begin
                step += (mu * stv) / ONE_Q;
            end else begin
                num = stv * slope;
                den = spv - slope;
                if (den == 0) begin
                    flag = 1;
                    q = (num > 0) ? QUOT_CLIP : ((num < 0) ? -QUOT_CLIP : 0);
                end else begin
                    q = num / den;
                    if (q > QUOT_CLIP) q = QUOT_CLIP;
                    if (q < -QUOT_CLIP) q = -QUOT_CLIP;
                end
                step += q;
            end
        end else begin
            step += (eps * slope) / ONE_Q;
        end
        nw = longint'(x.w) + step;
        if (nw > W_CLIP) nw = W_CLIP;
        if (nw < -W_CLIP) nw = -W_CLIP;
        if (step > 64'sd2147483647) begin
            step = 64'sd2147483647; flag = 1;
        end else if (step < -64'sd2147483648) begin
            step = -64'sd2147483648; flag = 1;
        end
        r.nw = nw[27:0];
        r.step = step[31:0];
        r.slope = slope[31:0];
        r.sat = flag;
        return r;
    endfunction

    // Pick a value: full range, small, or one of the boundaries
    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 5))
            0, 1: return $urandom;
            2, 3: return 32'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
            4: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return 32'($signed($urandom_range(0, 4000)) - 2000);
        endcase
    endfunction

    // Build a random item, often steered toward the step-dependent paths
    function automatic upd_in_t gen_item();
        upd_in_t x;
        longint sl;
        x.w = pick_word();
        if ($urandom_range(0, 3) == 0)
            x.w = $urandom_range(0, 1) ? 32'sd98304000 + $urandom_range(0, 1 << 20)
                                       : -32'sd98304000 - $urandom_range(0, 1 << 20);
        x.g = pick_word();
        case ($urandom_range(0, 5))
            0: x.stp = $urandom;
            1: x.stp = 32'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
            2: x.stp = $urandom_range(0, 1) ? 32'sd64 + $urandom_range(0, 2)
                                            : -32'sd66 + $urandom_range(0, 2);
            3: x.stp = 0;
            default: x.stp = $urandom_range(0, 1) ? 32'sd65536 * $urandom_range(1, 8)
                                                  : -32'sd65536 * $urandom_range(1, 8);
        endcase
        sl = raw_slope(x.w, x.g);
        case ($urandom_range(0, 4))
            0: x.sp = $urandom;
            1: x.sp = sl[31:0];
            2: x.sp = sl[31:0] + 32'($signed($urandom_range(0, 64)) - 32);
            default: x.sp = pick_word();
        endcase
        return x;
    endfunction

    task automatic report_mismatch(input string fld, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d", fld, got, want, cycles);
        errors++;
    endtask

    // Compare each finished transaction with the oldest expected update
    always @(posedge aclk) begin
        upd_res_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[92:0];
            if (updates_due.size() == 0) begin
                report_mismatch("unexpected transaction", 1, 0);
            end else begin
                want = updates_due.pop_front();
                if (got.nw !== want.nw) report_mismatch("new_weight", got.nw, want.nw);
                if (got.step !== want.step) report_mismatch("new_step", got.step, want.step);
                if (got.slope !== want.slope)
                    report_mismatch("new_slope", got.slope, want.slope);
                if (got.sat !== want.sat) report_mismatch("saturated", got.sat, want.sat);
            end
        end
    end

    // Bound the run
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYC_LIMIT) begin
            $display("FAIL quickprop_weight_update");
            $finish;
        end
    end

    // Result-side backpressure: random stalls, plus one long hold on request
    initial begin
        int stall_left;
        stall_left = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (long_hold) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYC) @(negedge aclk);
                long_hold = 0;
            end else begin
                if (!quiet && stall_left == 0 && $urandom_range(0, 5) == 0)
                    stall_left = $urandom_range(1, 19);
                m_tready <= (stall_left == 0) && aresetn;
                if (stall_left > 0) stall_left--;
            end
        end
    end

    // Offer one item and hold it until taken; optionally idle afterwards
    task automatic send_item(input upd_in_t x, input upd_res_t known_res, input bit known);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata <= x;
        do @(posedge aclk); while (!s_tready);
        updates_due.push_back(known ? known_res : predict_update(x));
        @(negedge aclk);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 19);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
    endtask

    // Let the pipeline drain before touching the registers; called at a falling edge
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (updates_due.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYC) @(negedge aclk);
    endtask

    // Offer one register write and return at the falling edge after it is taken
    task automatic write_reg(input reg_index_t idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_LRATE:  lr_q = val[30:0];
            REG_NBATCH: bs_q = val[15:0];
            REG_DECAY:  decay_q = val;
            REG_MU:     mu_q = val[30:0];
        endcase
        @(negedge aclk);
    endtask

    initial begin
        upd_res_t none;
        errors = 0;
        cycles = 0;
        quiet = 0;
        long_hold = 0;
        none = '0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_LRATE;
        cfg_data = '0;
        lr_q = LR_RST;
        bs_q = BS_RST;
        decay_q = DECAY_RST;
        mu_q = MU_RST;

        // Directed rows under reset registers
        dir_tab[0]  = '{'{32'sd0, 32'sd0, 32'sd0, 32'sd0}, 1, '{1'b0, 32'sd0, 32'sd0, 28'sd0}};
        // Zero secant divisor: quotient pins at -2^48, step saturates
        dir_tab[1]  = '{'{32'sd65536, -32'sd65536, -32'sd65536, 32'sd0}, 1,
                        '{1'b1, -32'sd65536, 32'h8000_0000, -28'sd98304000}};
        dir_tab[2]  = '{'{32'sd0, 32'sd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF}, 0, none};
        dir_tab[3]  = '{'{32'sd0, 32'sd0, 32'h8000_0000, 32'h8000_0000}, 0, none};
        dir_tab[4]  = '{'{32'sd65, 32'sd0, 32'sd300000, 32'sd1000}, 0, none};
        dir_tab[5]  = '{'{32'sd66, 32'sd0, 32'sd300000, 32'sd1000}, 0, none};
        dir_tab[6]  = '{'{-32'sd65, 32'sd0, -32'sd300000, 32'sd1000}, 0, none};
        dir_tab[7]  = '{'{-32'sd66, 32'sd0, -32'sd300000, 32'sd1000}, 0, none};
        dir_tab[8]  = '{'{32'sd65536, 32'sd0, 32'sd65536, 32'sd0}, 0, none};
        dir_tab[9]  = '{'{-32'sd65536, 32'sd0, -32'sd65536, 32'sd0}, 0, none};
        dir_tab[10] = '{'{32'sd65536, 32'sd65536, 32'sd32768, 32'sd0}, 0, none};
        dir_tab[11] = '{'{32'h7FFF_FFFF, -32'sd99999, -32'sd100000, 32'sd0}, 0, none};
        dir_tab[12] = '{'{32'sd0, 32'sd0, 32'sd0, 32'h7FFF_FFFF}, 0, none};
        dir_tab[13] = '{'{32'sd0, 32'sd0, 32'sd0, 32'h8000_0000}, 0, none};

        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (int i = 0; i < N_DIR; i++)
            send_item(dir_tab[i].din, dir_tab[i].res, dir_tab[i].known);

        for (int ph = 0; ph < 5; ph++) begin
            wait_drained();
            case (ph)
                0: ;
                1: begin
                    write_reg(REG_LRATE, 32'hFFFF_FFFF);
                    write_reg(REG_NBATCH, 32'd1);
                    write_reg(REG_DECAY, 32'h8000_0000);
                    write_reg(REG_MU, 32'h7FFF_FFFF);
                end
                2: begin
                    write_reg(REG_LRATE, 32'd0);
                    write_reg(REG_NBATCH, 32'hFFFF_FFFF);
                    write_reg(REG_DECAY, 32'h7FFF_FFFF);
                    write_reg(REG_MU, 32'd0);
                end
                3: begin
                    // Zero batch count acts as one
                    write_reg(REG_LRATE, $urandom);
                    write_reg(REG_NBATCH, 32'h0001_0000);
                    write_reg(REG_DECAY, 32'($signed($urandom_range(0, 1 << 18)) - (1 << 17)));
                    write_reg(REG_MU, $urandom_range(0, 1 << 19));
                end
                default: begin
                    quiet = 1;
                    write_reg(REG_LRATE, $urandom_range(0, 1 << 20));
                    write_reg(REG_NBATCH, $urandom_range(1, 64));
                    write_reg(REG_DECAY, $urandom);
                    write_reg(REG_MU, $urandom_range(1 << 15, 1 << 18));
                end
            endcase
            cfg_valid <= 1'b0;
            for (int n = 0; n < 200; n++) begin
                if (ph == 2 && n == 50) long_hold = 1;
                if (ph == 1 && n == 100) begin
                    // Pause input until the pipeline is empty
                    s_tvalid <= 1'b0;
                    while (updates_due.size() != 0) @(negedge aclk);
                end
                send_item(gen_item(), none, 0);
            end
        end

        s_tvalid <= 1'b0;
        while (updates_due.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYC) @(negedge aclk);
        if (errors == 0)
            $display("PASS quickprop_weight_update");
        else
            $display("FAIL quickprop_weight_update");
        $finish;
    end

endmodule

>>> quickprop_weight_update.f
rtl/qwu_pkg.sv
rtl/qwu_cfg.sv
rtl/qwu_front.sv
rtl/qwu_fifo.sv
rtl/qwu_back.sv
rtl/quickprop_weight_update.sv
rtl/qwu_checker.sv
tb/tb_quickprop_weight_update.sv
